[hdl/pfm_pkg.sv]
// ----------------------------------------------------------------------------
// Pulse frequency meter package
// Widths and the measurement record shared by the front end, queue and divider.
// ----------------------------------------------------------------------------
package pfm_pkg;

	localparam int TIMER_BITS = 16;
	localparam int CLK_W      = 27;
	localparam int TICK_W     = 16;
	localparam int STEP_W     = $clog2(CLK_W);
	localparam logic [CLK_W-1:0] CLOCK_RESET = CLK_W'(1000000);

	typedef struct packed {
		logic [TIMER_BITS-1:0] divisor;
		logic [TIMER_BITS-1:0] high;
		logic [TIMER_BITS-1:0] period;
	} job_t;

	typedef struct packed {
		logic push;
		logic full;
	} qctl_t;

endpackage

[hdl/pfm_front.sv]
// ----------------------------------------------------------------------------
// Pulse frequency meter front end
// Runs the tick counter, detects the watched edge and captures the counter.
// ----------------------------------------------------------------------------
module pfm_front import pfm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       signal_level,
	input  logic       q_full,
	output qctl_t      q_ctl,
	output job_t       q_job
);

	logic                  prev_q;
	logic [TIMER_BITS-1:0] tick_q;
	logic [1:0]            edges_q;
	logic                  watch_q;
	logic [TIMER_BITS-1:0] high_q;
	logic [TIMER_BITS-1:0] period_q;

	logic                  accept;
	logic                  hit;
	logic                  tick_clear;
	logic [TIMER_BITS-1:0] tick_next;

	assign in_stall   = q_full;
	assign accept     = in_valid && !q_full;
	assign tick_next  = tick_q + TIMER_BITS'(1);
	assign hit        = watch_q ? (prev_q && !signal_level) : (!prev_q && signal_level);
	assign tick_clear = hit && ((edges_q == 2'd0) || (edges_q == 2'd3));

	assign q_ctl.push    = accept && hit && (edges_q == 2'd3);
	assign q_ctl.full    = q_full;
	assign q_job.divisor = tick_next - high_q;
	assign q_job.high    = high_q;
	assign q_job.period  = period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= 1'b0;
			tick_q   <= '0;
			edges_q  <= 2'd0;
			watch_q  <= 1'b0;
			high_q   <= '0;
			period_q <= '0;
		end else if (accept) begin
			prev_q <= signal_level;
			tick_q <= tick_clear ? '0 : tick_next;
			if (hit) begin
				unique case (edges_q)
					2'd0: begin
						watch_q <= 1'b1;
						edges_q <= 2'd1;
					end
					2'd1: begin
						high_q  <= tick_next;
						watch_q <= 1'b0;
						edges_q <= 2'd2;
					end
					2'd2: begin
						period_q <= tick_next;
						watch_q  <= 1'b1;
						edges_q  <= 2'd3;
					end
					default: begin
						watch_q <= 1'b0;
						edges_q <= 2'd0;
					end
				endcase
			end
		end
	end

endmodule

[hdl/pfm_queue.sv]
// ----------------------------------------------------------------------------
// Pulse frequency meter job queue
// Two-entry queue of finished captures waiting for the divider.
// ----------------------------------------------------------------------------
module pfm_queue import pfm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  qctl_t ctl,
	input  job_t  wr_job,
	input  logic  pop,
	output logic  full,
	output logic  empty,
	output job_t  rd_job
);

	job_t       mem [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = ctl.push && !ctl.full;
	assign do_pop  = pop && !empty;
	assign rd_job  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

[hdl/pfm_back.sv]
// ----------------------------------------------------------------------------
// Pulse frequency meter divider back end
// Restoring divider, one quotient bit per cycle, with a registered output.
// ----------------------------------------------------------------------------
module pfm_back import pfm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CLK_W-1:0]  clock_hz,
	input  logic              q_empty,
	input  job_t              q_job,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CLK_W-1:0]  frequency_hz,
	output logic [TICK_W-1:0] high_ticks,
	output logic [TICK_W-1:0] period_ticks,
	output logic              divide_error
);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_t;

	state_t                state_q;
	logic [CLK_W-1:0]      quot_q;
	logic [TIMER_BITS-1:0] rem_q;
	logic [TIMER_BITS-1:0] div_q;
	logic [TIMER_BITS-1:0] high_q;
	logic [TIMER_BITS-1:0] period_q;
	logic                  zero_q;
	logic [STEP_W-1:0]     step_q;
	logic                  out_valid_q;

	logic [TIMER_BITS:0]   trial;
	logic [TIMER_BITS:0]   diff;
	logic                  qbit;
	logic                  out_free;

	assign trial    = {rem_q, quot_q[CLK_W-1]};
	assign diff     = trial - {1'b0, div_q};
	assign qbit     = !diff[TIMER_BITS];
	assign out_free = !out_valid_q || !out_stall;
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			step_q       <= '0;
			quot_q       <= '0;
			rem_q        <= '0;
			div_q        <= '0;
			high_q       <= '0;
			period_q     <= '0;
			zero_q       <= 1'b0;
			frequency_hz <= '0;
			high_ticks   <= '0;
			period_ticks <= '0;
			divide_error <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						quot_q   <= clock_hz;
						rem_q    <= '0;
						div_q    <= q_job.divisor;
						high_q   <= q_job.high;
						period_q <= q_job.period;
						zero_q   <= (q_job.divisor == '0);
						step_q   <= STEP_W'(CLK_W - 1);
						state_q  <= (q_job.divisor == '0) ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					quot_q <= {quot_q[CLK_W-2:0], qbit};
					rem_q  <= qbit ? diff[TIMER_BITS-1:0] : trial[TIMER_BITS-1:0];
					step_q <= step_q - STEP_W'(1);
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						frequency_hz <= zero_q ? '0 : quot_q;
						high_ticks   <= TICK_W'(high_q);
						period_ticks <= TICK_W'(period_q);
						divide_error <= zero_q;
						out_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[hdl/pulse_frequency_meter_unit.sv]
// ----------------------------------------------------------------------------
// Pulse frequency meter
// Input capture of high time and period, frequency by iterative division.
// ----------------------------------------------------------------------------
// Input channel: one item per timer tick carrying signal_level, handshake
// in_valid / in_stall. The tick counter and edge capture take one item per
// cycle while in_stall is low. After rising, falling, rising and falling
// edges a measurement is queued (two entries) for the divider.
// The divider produces one quotient bit per cycle. A capture passes the queue,
// the idle, divide and done states and the output register; a zero divisor
// skips divide. in_stall rises only while both queue entries are taken.
// Output channel: out_valid / out_stall with frequency_hz, high_ticks,
// period_ticks and divide_error; a stalled result holds while the divider
// finishes the next job behind it.
// Write clock_hz_q via cfg_write / cfg_data only while idle (not enforced).
// Reset: counter, captures and queue clear, clock rate returns to 1 MHz,
// the block first watches for a rising edge.
// ----------------------------------------------------------------------------
module pulse_frequency_meter_unit import pfm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [CLK_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              signal_level,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CLK_W-1:0]  frequency_hz,
	output logic [TICK_W-1:0] high_ticks,
	output logic [TICK_W-1:0] period_ticks,
	output logic              divide_error
);

	logic [CLK_W-1:0] clock_hz_q;
	qctl_t            q_ctl;
	job_t             push_job;
	job_t             pop_job;
	logic             q_full;
	logic             q_empty;
	logic             q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= CLOCK_RESET;
		end else if (cfg_write) begin
			clock_hz_q <= cfg_data;
		end
	end

	pfm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.signal_level (signal_level),
		.q_full       (q_full),
		.q_ctl        (q_ctl),
		.q_job        (push_job)
	);

	pfm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (q_ctl),
		.wr_job (push_job),
		.pop    (q_pop),
		.full   (q_full),
		.empty  (q_empty),
		.rd_job (pop_job)
	);

	pfm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.clock_hz     (clock_hz_q),
		.q_empty      (q_empty),
		.q_job        (pop_job),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frequency_hz (frequency_hz),
		.high_ticks   (high_ticks),
		.period_ticks (period_ticks),
		.divide_error (divide_error)
	);

endmodule
